// ----- src/acm_pkg.sv -----
// Package for the decimal accumulator machine: sizes, limits, instruction and
// status codes, sequencer states and the program-word check.
// Depends on nothing; used by accumulator_machine_step, acm_checker and tb.
`default_nettype none

package acm_pkg;

  localparam int STORE_WORDS = 100;
  localparam int ADDR_W      = $clog2(STORE_WORDS);
  localparam int PWORD_W     = 13;
  localparam int DWORD_W     = 15;
  localparam int MAG_W       = 14;
  localparam int PROD_W      = 28;
  localparam int ALU_W       = 29;
  localparam int ACC_LIM     = 9999;
  localparam int WORD_BASE   = 100;

  // Reciprocal of one hundred, exact for every 13-bit program word.
  localparam int DEC_RECIP   = 5243;
  localparam int DEC_SHIFT   = 19;
  localparam int DEC_PROD_W  = 26;

  localparam logic [PWORD_W-1:0] HALT_WORD = PWORD_W'(4300);

  typedef enum logic [1:0] {
    OPC_LOAD  = 2'd0,
    OPC_STEP  = 2'd1,
    OPC_START = 2'd2,
    OPC_NONE  = 2'd3
  } opc_t;

  localparam logic [6:0] INS_READ   = 7'd10;
  localparam logic [6:0] INS_WRITE  = 7'd11;
  localparam logic [6:0] INS_LOAD   = 7'd20;
  localparam logic [6:0] INS_STORE  = 7'd21;
  localparam logic [6:0] INS_ADD    = 7'd30;
  localparam logic [6:0] INS_SUB    = 7'd31;
  localparam logic [6:0] INS_DIV    = 7'd32;
  localparam logic [6:0] INS_MUL    = 7'd33;
  localparam logic [6:0] INS_BR     = 7'd40;
  localparam logic [6:0] INS_BRNEG  = 7'd41;
  localparam logic [6:0] INS_BRZERO = 7'd42;

  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_WRITTEN  = 3'd1;
  localparam logic [2:0] STAT_HALTED   = 3'd2;
  localparam logic [2:0] STAT_OVERFLOW = 3'd3;
  localparam logic [2:0] STAT_LOAD_REJ = 3'd4;
  localparam logic [2:0] STAT_READ_REJ = 3'd5;
  localparam logic [2:0] STAT_OFF_END  = 3'd6;
  localparam logic [2:0] STAT_IDLE     = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_FETCH,
    ST_DECODE,
    ST_MOD,
    ST_DREAD,
    ST_EXEC,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_RESULT
  } state_t;

  // A program word is accepted only inside one of the four opcode bands.
  function automatic logic word_allowed(input logic signed [DWORD_W-1:0] w);
    logic ok;
    ok = (w >= DWORD_W'(1000) && w <= DWORD_W'(1199)) ||
         (w >= DWORD_W'(2000) && w <= DWORD_W'(2199)) ||
         (w >= DWORD_W'(3000) && w <= DWORD_W'(3399)) ||
         (w >= DWORD_W'(4000) && w <= DWORD_W'(4399));
    return ok;
  endfunction

endpackage

`default_nettype wire

// ----- src/acm_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module acm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- src/accumulator_machine_step.sv -----
// Decimal accumulator machine, top level: sequencer, shared add/subtract unit,
// program and data stores. Depends on acm_pkg and acm_ram.
//
// Usage. An input beat carries an opcode: load a program word at an address,
// start a run (clears accumulator and program counter), or execute one
// instruction, where the value field feeds a READ. Every input beat yields
// exactly one result beat with a status, the WRITE value, and the
// accumulator and program counter after the beat.
// The block works on one beat at a time and drops in_ready while it does.
// Load, start, idle and ran-off-end beats pass dispatch and go to the result,
// a HALT also passes the fetch. An executed instruction goes through dispatch,
// one program store read with a reciprocal multiply that yields the opcode,
// one shared-adder step for the operand, one step that folds the operand
// into the store, one data store read, execute and the hand-off to the
// output register. MULTIPLY, and DIVIDE by a nonzero value, add 14
// shift-add or shift-subtract steps plus a sign fix. The operand split,
// ADD, SUBTRACT, the multiply and divide steps and the sign fix go through
// one shared 29-bit adder. A new beat is accepted in the cycle after the
// result is handed off.
// The result sits in an output register; the next beat is accepted as soon
// as the sequencer is back in idle, even while the receiver stalls. A new
// result waits in the sequencer until the output register is free.
// Reset clears the accumulator, program counter and run flag, and the valid
// bits of both stores, so unwritten words read as zero. No clearing pass.
`default_nettype none

module accumulator_machine_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic [6:0]         in_address,
  input  logic signed [14:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic signed [14:0] out_out_value,
  output logic signed [14:0] out_acc_now,
  output logic [6:0]         out_pc_now
);

  import acm_pkg::*;

  // Sequencer and architectural state.
  state_t state_r, state_nxt;
  logic running_r, running_nxt;
  logic signed [DWORD_W-1:0] acc_r, acc_nxt;
  logic [6:0] pc_r, pc_nxt;

  // Latched input beat.
  opc_t opc_r, opc_nxt;
  logic [6:0] addr_r, addr_nxt;
  logic signed [DWORD_W-1:0] val_r, val_nxt;

  // Working registers of the shared unit.
  logic [DWORD_W-1:0] rem_r, rem_nxt;
  logic [MAG_W-1:0] q_r, q_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [6:0] arg_r, arg_nxt;
  logic [6:0] instr_r, instr_nxt;
  logic [ADDR_W-1:0] slot_r, slot_nxt;
  logic signed [DWORD_W-1:0] mem_r, mem_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [PROD_W-1:0] mcand_r, mcand_nxt;
  logic [MAG_W-1:0] opnd_r, opnd_nxt;
  logic neg_r, neg_nxt;
  logic isdiv_r, isdiv_nxt;
  logic [2:0] res_status_r, res_status_nxt;
  logic signed [DWORD_W-1:0] res_outval_r, res_outval_nxt;

  // Output register.
  logic out_valid_r, out_valid_nxt;
  logic [2:0] out_status_r, out_status_nxt;
  logic signed [DWORD_W-1:0] out_value_r, out_value_nxt;
  logic signed [DWORD_W-1:0] out_acc_r, out_acc_nxt;
  logic [6:0] out_pc_r, out_pc_nxt;

  // Stores and their valid bits.
  logic pvalid_r [STORE_WORDS];
  logic dvalid_r [STORE_WORDS];
  logic pv_q_r, dv_q_r;
  logic pwe, dwe;
  logic [DWORD_W-1:0] dwdata;
  logic [PWORD_W-1:0] prd;
  logic [DWORD_W-1:0] drd;
  logic [PWORD_W-1:0] fetch_word;

  // Shared adder.
  logic signed [ALU_W-1:0] alu_a, alu_b, alu_sum;
  logic alu_sub, alu_neg;

  logic [MAG_W-1:0] acc_mag, mem_mag;
  logic [DWORD_W-1:0] div_part;
  logic [PROD_W-1:0] fin_mag;
  logic [6:0] pc_inc;
  logic [DEC_PROD_W-1:0] dec_prod;

  acm_ram #(.WIDTH(PWORD_W), .DEPTH(STORE_WORDS)) u_prog_ram (
    .clk   (clk),
    .we    (pwe),
    .waddr (addr_r[ADDR_W-1:0]),
    .wdata (val_r[PWORD_W-1:0]),
    .raddr (pc_r[ADDR_W-1:0]),
    .rdata (prd)
  );

  acm_ram #(.WIDTH(DWORD_W), .DEPTH(STORE_WORDS)) u_data_ram (
    .clk   (clk),
    .we    (dwe),
    .waddr (slot_r),
    .wdata (dwdata),
    .raddr (rem_r[ADDR_W-1:0]),
    .rdata (drd)
  );

  // An entry that was never written reads as zero.
  assign fetch_word = pv_q_r ? prd : '0;

  // The high decimal digits of the word by reciprocal multiplication.
  assign dec_prod = DEC_PROD_W'(fetch_word) * DEC_PROD_W'(DEC_RECIP);

  assign acc_mag  = acc_r[DWORD_W-1] ? MAG_W'(-acc_r) : MAG_W'(acc_r);
  assign mem_mag  = mem_r[DWORD_W-1] ? MAG_W'(-mem_r) : MAG_W'(mem_r);
  assign div_part = {rem_r[MAG_W-1:0], opnd_r[MAG_W-1]};
  assign fin_mag  = isdiv_r ? PROD_W'(q_r) : prod_r;
  assign pc_inc   = pc_r + 7'd1;

  assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);
  assign alu_neg = alu_sum[ALU_W-1];

  // Operand selection for the shared adder, one use per sequencer state.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_r)
      ST_DECODE: begin
        alu_a   = ALU_W'(rem_r);
        alu_b   = ALU_W'(q_r[6:0]) * ALU_W'(WORD_BASE);
        alu_sub = 1'b1;
      end
      ST_MOD: begin
        alu_a   = ALU_W'(rem_r);
        alu_b   = ALU_W'(STORE_WORDS);
        alu_sub = 1'b1;
      end
      ST_EXEC: begin
        alu_a   = ALU_W'(acc_r);
        alu_b   = ALU_W'(mem_r);
        alu_sub = (instr_r == INS_SUB);
      end
      ST_MUL: begin
        alu_a = ALU_W'(prod_r);
        alu_b = opnd_r[0] ? ALU_W'(mcand_r) : '0;
      end
      ST_DIV: begin
        alu_a   = ALU_W'(div_part);
        alu_b   = ALU_W'(mcand_r);
        alu_sub = 1'b1;
      end
      ST_FIN: begin
        alu_b   = ALU_W'(fin_mag);
        alu_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Next state and datapath control.
  always_comb begin
    state_nxt      = state_r;
    running_nxt    = running_r;
    acc_nxt        = acc_r;
    pc_nxt         = pc_r;
    opc_nxt        = opc_r;
    addr_nxt       = addr_r;
    val_nxt        = val_r;
    rem_nxt        = rem_r;
    q_nxt          = q_r;
    cnt_nxt        = cnt_r;
    arg_nxt        = arg_r;
    instr_nxt      = instr_r;
    slot_nxt       = slot_r;
    mem_nxt        = mem_r;
    prod_nxt       = prod_r;
    mcand_nxt      = mcand_r;
    opnd_nxt       = opnd_r;
    neg_nxt        = neg_r;
    isdiv_nxt      = isdiv_r;
    res_status_nxt = res_status_r;
    res_outval_nxt = res_outval_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_acc_nxt    = out_acc_r;
    out_pc_nxt     = out_pc_r;
    pwe            = 1'b0;
    dwe            = 1'b0;
    dwdata         = val_r;
    in_ready       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          opc_nxt   = opc_t'(in_opcode);
          addr_nxt  = in_address;
          val_nxt   = in_value;
          state_nxt = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        res_outval_nxt = '0;
        state_nxt      = ST_RESULT;
        unique case (opc_r)
          OPC_LOAD: begin
            if (addr_r < 7'(STORE_WORDS) && word_allowed(val_r)) begin
              pwe            = 1'b1;
              res_status_nxt = STAT_OK;
            end else begin
              res_status_nxt = STAT_LOAD_REJ;
            end
          end
          OPC_STEP: begin
            if (!running_r) begin
              res_status_nxt = STAT_IDLE;
            end else if (pc_r >= 7'(STORE_WORDS)) begin
              running_nxt    = 1'b0;
              res_status_nxt = STAT_OFF_END;
            end else begin
              // The program store is read at pc_r in this cycle.
              state_nxt = ST_FETCH;
            end
          end
          OPC_START: begin
            acc_nxt        = '0;
            pc_nxt         = '0;
            running_nxt    = 1'b1;
            res_status_nxt = STAT_OK;
          end
          OPC_NONE: begin
            res_status_nxt = STAT_IDLE;
          end
          default: begin
            res_status_nxt = STAT_IDLE;
          end
        endcase
      end

      ST_FETCH: begin
        if (fetch_word == HALT_WORD) begin
          running_nxt    = 1'b0;
          res_status_nxt = STAT_HALTED;
          state_nxt      = ST_RESULT;
        end else begin
          rem_nxt   = DWORD_W'(fetch_word);
          q_nxt     = MAG_W'(dec_prod[DEC_SHIFT +: 7]);
          state_nxt = ST_DECODE;
        end
      end

      // The operand is what is left after taking off the opcode hundreds.
      ST_DECODE: begin
        rem_nxt   = alu_sum[DWORD_W-1:0];
        arg_nxt   = alu_sum[6:0];
        instr_nxt = q_r[6:0];
        state_nxt = ST_MOD;
      end

      // Fold the operand into the data store; the read is issued on exit.
      ST_MOD: begin
        if (!alu_neg) begin
          rem_nxt = alu_sum[DWORD_W-1:0];
        end else begin
          slot_nxt  = rem_r[ADDR_W-1:0];
          state_nxt = ST_DREAD;
        end
      end

      ST_DREAD: begin
        mem_nxt   = dv_q_r ? drd : '0;
        state_nxt = ST_EXEC;
      end

      ST_EXEC: begin
        res_status_nxt = STAT_OK;
        state_nxt      = ST_RESULT;
        pc_nxt         = pc_inc;
        case (instr_r) inside
          INS_READ: begin
            if (val_r > DWORD_W'(ACC_LIM) || val_r < DWORD_W'(-ACC_LIM)) begin
              res_status_nxt = STAT_READ_REJ;
              pc_nxt         = pc_r;
            end else begin
              dwe = 1'b1;
            end
          end
          INS_WRITE: begin
            res_outval_nxt = acc_r;
            res_status_nxt = STAT_WRITTEN;
          end
          INS_LOAD: begin
            acc_nxt = mem_r;
          end
          INS_STORE: begin
            dwe    = 1'b1;
            dwdata = acc_r;
          end
          INS_ADD, INS_SUB: begin
            if (alu_sum > ALU_W'(ACC_LIM) || alu_sum < ALU_W'(-ACC_LIM)) begin
              acc_nxt        = '0;
              running_nxt    = 1'b0;
              pc_nxt         = pc_r;
              res_status_nxt = STAT_OVERFLOW;
            end else begin
              acc_nxt = alu_sum[DWORD_W-1:0];
            end
          end
          INS_DIV: begin
            // A zero divisor leaves the accumulator as it is.
            if (mem_r != '0) begin
              pc_nxt    = pc_r;
              rem_nxt   = '0;
              q_nxt     = '0;
              opnd_nxt  = acc_mag;
              mcand_nxt = PROD_W'(mem_mag);
              neg_nxt   = acc_r[DWORD_W-1] ^ mem_r[DWORD_W-1];
              isdiv_nxt = 1'b1;
              cnt_nxt   = '0;
              state_nxt = ST_DIV;
            end
          end
          INS_MUL: begin
            pc_nxt    = pc_r;
            prod_nxt  = '0;
            opnd_nxt  = acc_mag;
            mcand_nxt = PROD_W'(mem_mag);
            neg_nxt   = acc_r[DWORD_W-1] ^ mem_r[DWORD_W-1];
            isdiv_nxt = 1'b0;
            cnt_nxt   = '0;
            state_nxt = ST_MUL;
          end
          INS_BR: begin
            pc_nxt = arg_r;
          end
          INS_BRNEG: begin
            if (acc_r[DWORD_W-1]) begin
              pc_nxt = arg_r;
            end
          end
          INS_BRZERO: begin
            if (acc_r == '0) begin
              pc_nxt = arg_r;
            end
          end
          default: begin
          end
        endcase
      end

      // Shift-add multiply of magnitudes, one multiplier bit a cycle.
      ST_MUL: begin
        prod_nxt  = alu_sum[PROD_W-1:0];
        mcand_nxt = mcand_r << 1;
        opnd_nxt  = opnd_r >> 1;
        cnt_nxt   = cnt_r + 4'd1;
        if (cnt_r == 4'(MAG_W - 1)) begin
          state_nxt = ST_FIN;
        end
      end

      // Restoring divide of magnitudes, one quotient bit a cycle.
      ST_DIV: begin
        rem_nxt  = alu_neg ? div_part : alu_sum[DWORD_W-1:0];
        q_nxt    = {q_r[MAG_W-2:0], ~alu_neg};
        opnd_nxt = opnd_r << 1;
        cnt_nxt  = cnt_r + 4'd1;
        if (cnt_r == 4'(MAG_W - 1)) begin
          state_nxt = ST_FIN;
        end
      end

      // Range check on the magnitude, then apply the sign.
      ST_FIN: begin
        state_nxt = ST_RESULT;
        if (fin_mag > PROD_W'(ACC_LIM)) begin
          acc_nxt        = '0;
          running_nxt    = 1'b0;
          res_status_nxt = STAT_OVERFLOW;
        end else begin
          acc_nxt        = neg_r ? alu_sum[DWORD_W-1:0] : fin_mag[DWORD_W-1:0];
          pc_nxt         = pc_inc;
          res_status_nxt = STAT_OK;
        end
      end

      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_outval_r;
          out_acc_nxt    = acc_r;
          out_pc_nxt     = pc_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      running_r   <= 1'b0;
      acc_r       <= '0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      running_r   <= running_nxt;
      acc_r       <= acc_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Per-word valid bits; the lookups are registered alongside the RAM reads.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STORE_WORDS; i++) begin
        pvalid_r[i] <= 1'b0;
        dvalid_r[i] <= 1'b0;
      end
      pv_q_r <= 1'b0;
      dv_q_r <= 1'b0;
    end else begin
      if (pwe) begin
        pvalid_r[addr_r[ADDR_W-1:0]] <= 1'b1;
      end
      if (dwe) begin
        dvalid_r[slot_r] <= 1'b1;
      end
      pv_q_r <= pvalid_r[pc_r[ADDR_W-1:0]];
      dv_q_r <= dvalid_r[rem_r[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    opc_r        <= opc_nxt;
    addr_r       <= addr_nxt;
    val_r        <= val_nxt;
    rem_r        <= rem_nxt;
    q_r          <= q_nxt;
    cnt_r        <= cnt_nxt;
    arg_r        <= arg_nxt;
    instr_r      <= instr_nxt;
    slot_r       <= slot_nxt;
    mem_r        <= mem_nxt;
    prod_r       <= prod_nxt;
    mcand_r      <= mcand_nxt;
    opnd_r       <= opnd_nxt;
    neg_r        <= neg_nxt;
    isdiv_r      <= isdiv_nxt;
    res_status_r <= res_status_nxt;
    res_outval_r <= res_outval_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_acc_r    <= out_acc_nxt;
    out_pc_r     <= out_pc_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_out_value = out_value_r;
  assign out_acc_now   = out_acc_r;
  assign out_pc_now    = out_pc_r;

  // The accumulator never leaves the four-digit range.
  a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_r <= DWORD_W'(ACC_LIM) && acc_r >= DWORD_W'(-ACC_LIM)))
    else $error("accumulator out of range");

  // Word split yields an operand below one hundred and a plausible opcode.
  a_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MOD) |-> (arg_r < 7'(WORD_BASE) && instr_r <= 7'd81))
    else $error("instruction word split out of range");

  // The partial remainder of a divide stays below the divisor.
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (PROD_W'(rem_r) < mcand_r))
    else $error("divide remainder not below divisor");

endmodule

`default_nettype wire

// ----- test/acm_checker.sv -----
// Result checker for the decimal accumulator machine: watches the input and
// result channels, predicts every result beat and compares it field by field.
// Depends on acm_pkg.
`default_nettype none

module acm_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic [6:0]         in_address,
  input  logic signed [14:0] in_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [2:0]         out_status,
  input  logic signed [14:0] out_out_value,
  input  logic signed [14:0] out_acc_now,
  input  logic [6:0]         out_pc_now,
  output int                 fail_count,
  output int                 pending_count,
  output int                 result_count,
  output int                 write_count,
  output int                 overflow_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import acm_pkg::*;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [14:0] wval;
    logic signed [14:0] acc;
    logic [6:0]         pc;
  } machine_result_t;

  int              prog_mem [STORE_WORDS];
  int              data_mem [STORE_WORDS];
  int              acc_q;
  int              pc_q;
  bit              run_q;
  machine_result_t expected_q[$];

  function automatic bit load_ok(int w);
    return (w >= 1000 && w <= 1199) || (w >= 2000 && w <= 2199) ||
           (w >= 3000 && w <= 3399) || (w >= 4000 && w <= 4399);
  endfunction

  // One instruction step; returns status and sets the written value.
  function automatic logic [2:0] exec_instr(int inval, ref int wval);
    int w, op, arg, slot, mem, acc, nxt;
    logic [2:0] st;
    st = STAT_OK;
    if (!run_q) return STAT_IDLE;
    if (pc_q >= STORE_WORDS) begin
      run_q = 0;
      return STAT_OFF_END;
    end
    w = prog_mem[pc_q];
    if (w == 4300) begin
      run_q = 0;
      return STAT_HALTED;
    end
    op = w / 100;
    arg = w % 100;
    if (arg < 0) arg = 0;
    slot = arg % STORE_WORDS;
    mem = data_mem[slot];
    acc = acc_q;
    nxt = pc_q + 1;
    case (op)
      INS_READ: begin
        if (inval > ACC_LIM || inval < -ACC_LIM) return STAT_READ_REJ;
        data_mem[slot] = inval;
      end
      INS_WRITE: begin
        wval = acc;
        st = STAT_WRITTEN;
      end
      INS_LOAD:   acc = mem;
      INS_STORE:  data_mem[slot] = acc;
      INS_ADD:    acc = acc + mem;
      INS_SUB:    acc = acc - mem;
      INS_DIV:    if (mem != 0) acc = acc / mem;
      INS_MUL:    acc = acc * mem;
      INS_BR:     nxt = arg;
      INS_BRNEG:  if (acc < 0) nxt = arg;
      INS_BRZERO: if (acc == 0) nxt = arg;
      default: ;
    endcase
    if (acc > ACC_LIM || acc < -ACC_LIM) begin
      acc_q = 0;
      run_q = 0;
      wval = 0;
      return STAT_OVERFLOW;
    end
    acc_q = acc;
    pc_q = nxt;
    return st;
  endfunction

  function automatic machine_result_t predict_beat(logic [1:0] opc, logic [6:0] addr,
                                                    logic signed [14:0] val);
    machine_result_t r;
    int wv;
    wv = 0;
    case (opc)
      OPC_LOAD: begin
        if (addr < STORE_WORDS && load_ok(val)) begin
          prog_mem[addr] = val;
          r.status = STAT_OK;
        end else begin
          r.status = STAT_LOAD_REJ;
        end
      end
      OPC_STEP: r.status = exec_instr(val, wv);
      OPC_START: begin
        acc_q = 0;
        pc_q = 0;
        run_q = 1;
        r.status = STAT_OK;
      end
      default: r.status = STAT_IDLE;
    endcase
    r.wval = 15'(wv);
    r.acc = 15'(acc_q);
    r.pc = 7'(pc_q);
    return r;
  endfunction

  assign pending_count = expected_q.size();

  always @(posedge clk) begin
    machine_result_t e;
    if (!rst_n) begin
      foreach (prog_mem[i]) prog_mem[i] = 0;
      foreach (data_mem[i]) data_mem[i] = 0;
      acc_q = 0;
      pc_q = 0;
      run_q = 0;
      expected_q.delete();
      fail_count <= 0;
      result_count <= 0;
      write_count <= 0;
      overflow_count <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_q.push_back(predict_beat(in_opcode, in_address, in_value));
      if (out_valid && out_ready) begin
        result_count <= result_count + 1;
        if (out_status == STAT_WRITTEN) write_count <= write_count + 1;
        if (out_status == STAT_OVERFLOW) overflow_count <= overflow_count + 1;
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected, status %0d", out_status);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (out_status !== e.status || out_out_value !== e.wval ||
              out_acc_now !== e.acc || out_pc_now !== e.pc) begin
            if (out_status !== e.status)
              $error("status: expected %0d, got %0d", e.status, out_status);
            if (out_out_value !== e.wval)
              $error("out_value: expected %0d, got %0d", e.wval, out_out_value);
            if (out_acc_now !== e.acc)
              $error("acc_now: expected %0d, got %0d", e.acc, out_acc_now);
            if (out_pc_now !== e.pc)
              $error("pc_now: expected %0d, got %0d", e.pc, out_pc_now);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Testbench top for the decimal accumulator machine: clock, reset, stimulus,
// receiver stalls and the verdict. Depends on acm_pkg, acm_checker and the block.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import acm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_opcode;
  logic [6:0]         in_address;
  logic signed [14:0] in_value;
  logic               out_valid;
  logic               out_ready;
  logic [2:0]         out_status;
  logic signed [14:0] out_out_value;
  logic signed [14:0] out_acc_now;
  logic [6:0]         out_pc_now;
  int                 fail_count, pending_count, result_count;
  int                 write_count, overflow_count;
  int                 cycle_count;
  int                 beats_sent;

  // Idle and stall percentages for the current phase; the hold-off flag
  // forces a long receiver stall while the sender keeps pushing beats.
  int                 send_idle_pct;
  int                 recv_stall_pct;
  bit                 hold_off;

  accumulator_machine_step i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_opcode(in_opcode),
    .in_address(in_address), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_out_value(out_out_value), .out_acc_now(out_acc_now), .out_pc_now(out_pc_now)
  );

  acm_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_opcode(in_opcode),
    .in_address(in_address), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_out_value(out_out_value), .out_acc_now(out_acc_now), .out_pc_now(out_pc_now),
    .fail_count(fail_count), .pending_count(pending_count),
    .result_count(result_count), .write_count(write_count),
    .overflow_count(overflow_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // The receiver stalls at random, or for a long counted stretch on request.
  initial begin
    int hold_left;
    out_ready = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off && hold_left == 0) hold_left = 300;
      if (hold_left > 0) begin
        hold_left--;
        if (hold_left == 0) hold_off = 0;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Send one beat: optional idle cycles first, then hold valid until accepted.
  task automatic send_beat(logic [1:0] opc, logic [6:0] addr, logic signed [14:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= opc;
    in_address <= addr;
    in_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic finish_beats();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every predicted result has come back.
  task automatic drain();
    finish_beats();
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic load_word(int a, int w);
    send_beat(OPC_LOAD, 7'(a), 15'(w));
  endtask

  // A random instruction word, biased toward legal encodings with small
  // operands so that programs actually run and touch the data store.
  function automatic int rand_instr();
    int ops[11] = '{10, 11, 20, 21, 30, 31, 32, 33, 40, 41, 42};
    int k;
    k = $urandom_range(99);
    if (k < 4) return 4300;
    if (k < 6) return 4300 + $urandom_range(1, 99);
    if (k < 8) return 1000 + $urandom_range(100, 199);
    return ops[$urandom_range(10)] * 100 + $urandom_range(15);
  endfunction

  // A random data value: mostly small, sometimes near the limits or beyond.
  function automatic int rand_data();
    int k;
    k = $urandom_range(99);
    if (k < 60) return $urandom_range(40) - 20;
    if (k < 80) return $urandom_range(19998) - 9999;
    if (k < 90) return (k & 1) ? 9999 : -9999;
    return $urandom_range(32767) - 16384;
  endfunction

  // One random program of short length, then start and a run of steps.
  task automatic random_program();
    int len, steps;
    len = $urandom_range(3, 14);
    for (int a = 0; a < len; a++) load_word(a, rand_instr());
    if ($urandom_range(3) == 0) load_word(len, 4300);
    send_beat(OPC_START, 7'($urandom), 15'($urandom));
    steps = $urandom_range(4, 20);
    for (int s = 0; s < steps; s++) begin
      if ($urandom_range(19) == 0)
        send_beat(2'($urandom_range(3)), 7'($urandom), 15'($urandom));
      else
        send_beat(OPC_STEP, 7'($urandom), 15'(rand_data()));
    end
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int n_beats);
    int target;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    target = beats_sent + n_beats;
    while (beats_sent < target) begin
      if ($urandom_range(9) == 0)
        send_beat(2'($urandom_range(3)), 7'($urandom), 15'($urandom));
      else
        random_program();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OPC_LOAD;
    in_address = '0;
    in_value = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 0;
    beats_sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: a step before any start, load rejections just outside the
    // first and last band and at bad addresses, then a program that reads and
    // multiplies, and a restart that loops on a branch on zero until a HALT.
    send_beat(OPC_STEP, 7'd0, 15'd0);
    send_beat(OPC_NONE, 7'd127, -15'sd16384);
    load_word(0, 999);
    load_word(0, 1200);
    load_word(0, 4400);
    load_word(100, 1000);
    load_word(127, 16383);
    load_word(0, 1050);     // READ 50
    load_word(1, 3350);     // MULTIPLY by word 50
    load_word(2, 1150);     // WRITE
    load_word(3, 3250);     // DIVIDE
    load_word(4, 4099);     // BRANCH to 99
    load_word(99, 4399);    // no-op word, then run off the end
    send_beat(OPC_START, 7'd0, 15'd0);
    send_beat(OPC_STEP, 7'd0, 15'sd10000);  // read rejected
    send_beat(OPC_STEP, 7'd0, -15'sd9999);
    send_beat(OPC_STEP, 7'd0, 15'd0);       // multiply of a zero accumulator
    send_beat(OPC_START, 7'd0, 15'd0);
    load_word(1, 4200);     // BRANCHZERO 0 loops on READ
    send_beat(OPC_STEP, 7'd0, 15'sd0);
    send_beat(OPC_STEP, 7'd0, 15'sd0);
    load_word(1, 4300);
    send_beat(OPC_STEP, 7'd0, 15'sd7);
    send_beat(OPC_STEP, 7'd0, 15'sd0);      // halt
    send_beat(OPC_STEP, 7'd0, 15'sd0);      // idle after halt

    // Random phases with different idle and stall mixes.
    run_phase(0, 0, 120);
    run_phase(75, 0, 120);
    run_phase(0, 75, 120);

    // Long receiver hold-off while the sender keeps offering beats.
    hold_off = 1;
    run_phase(0, 0, 40);
    // Sender pause until everything has drained.
    drain();
    run_phase(26, 26, 120);
    run_phase(0, 0, 120);

    drain();
    repeat (50) @(posedge clk);
    $display("Sent %0d beats and checked %0d results, %0d writes and %0d overflows.",
             beats_sent, result_count, write_count, overflow_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
src/acm_pkg.sv
src/acm_ram.sv
src/accumulator_machine_step.sv
test/acm_checker.sv
test/tb.sv
